FILE: hdl/jsle_pkg.sv
// Shared types, constants and helpers for the JSON list extractor.
`timescale 1ns / 1ps
package jsle_pkg;

  localparam int DEPTH_BITS  = 8;
  localparam int INDEX_BITS  = 24;
  localparam int ERR_INDEX_W = 24;
  localparam int KEY_POS_W   = 4;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
  localparam logic [KEY_POS_W-1:0]  KEY_POS_MAX = '1;

  localparam logic [KEY_POS_W-1:0] KEY_WORDS_LEN   = KEY_POS_W'(11);
  localparam logic [KEY_POS_W-1:0] KEY_SERVERS_LEN = KEY_POS_W'(7);

  localparam logic [7:0] KEY_WORDS [11] = '{
    "s", "e", "a", "r", "c", "h", "W", "o", "r", "d", "s"
  };
  localparam logic [7:0] KEY_SERVERS [7] = '{
    "s", "e", "r", "v", "e", "r", "s"
  };

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef enum logic [3:0] {
    PH_OPEN, PH_KEYWAIT, PH_KEY, PH_COLON, PH_VALUE, PH_SKIPSTR,
    PH_SKIPARR, PH_ARR, PH_ELEM, PH_ARRNEXT, PH_NEXT, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_BRACE, ERR_STRING, ERR_COLON, ERR_VALUE_TYPE,
    ERR_BRACKET, ERR_UNTERMINATED
  } err_kind_t;

  typedef enum logic [1:0] {
    ST_RUNNING, ST_COMPLETED, ST_FAILED
  } status_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // True while the key byte at this position still agrees with "searchWords".
  function automatic logic words_match(input logic [KEY_POS_W-1:0] pos,
                                       input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (pos < KEY_WORDS_LEN) hit = (KEY_WORDS[pos] == b);
    return hit;
  endfunction

  function automatic logic servers_match(input logic [KEY_POS_W-1:0] pos,
                                         input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (pos < KEY_SERVERS_LEN) hit = (KEY_SERVERS[pos[2:0]] == b);
    return hit;
  endfunction

endpackage

FILE: hdl/jsle_byte_if.sv
// Input channel: one file byte per request.
`timescale 1ns / 1ps
interface jsle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, output byte_value, output last, input ready);
  modport sink   (input valid, input byte_value, input last, output ready);
endinterface

FILE: hdl/jsle_result_if.sv
// Output channel: one parse result per request.
`timescale 1ns / 1ps
interface jsle_result_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [7:0]  char_value;
  logic        list_id;
  logic        list_start;
  logic        element_end;
  logic [1:0]  status;
  logic [2:0]  error_kind;
  logic [23:0] error_index;

  modport source (output valid, output char_valid, output char_value, output list_id,
                  output list_start, output element_end, output status,
                  output error_kind, output error_index, input ready);
  modport sink   (input valid, input char_valid, input char_value, input list_id,
                  input list_start, input element_end, input status,
                  input error_kind, input error_index, output ready);
endinterface

FILE: hdl/json_subset_list_extractor_unit.sv
// Streaming JSON subset parser that extracts the strings of two named lists.
//
//   channel   | dir | payload                                   | handshake
//   ----------+-----+-------------------------------------------+------------
//   byte_in   | in  | byte_value, last                          | valid/ready
//   result    | out | char_valid, char_value, list_id,          | valid/ready
//             |     | list_start, element_end, status,          |
//             |     | error_kind, error_index                   |
//
// One byte per cycle while results are drained: each accepted byte moves the parser
// state and writes its result into the output register in the same cycle, so the rate
// is one request per clock, set by the single parse step between the input port and that register.
// The result is valid in the cycle after the byte is accepted.
// Reset (rst, synchronous) returns the parser to waiting for the opening brace
// and empties the output register; the byte flagged last also returns the parser
// to that state, while its result still loads the output register.
// A stalled result holds in the output register; a new byte is taken only when
// that register is empty or being drained in the same cycle.
`timescale 1ns / 1ps
module json_subset_list_extractor_unit (
  input logic           clk,
  input logic           rst,
  jsle_byte_if.sink     byte_in,
  jsle_result_if.source result
);
  import jsle_pkg::*;

  // Parser state.
  phase_t                  phase, phase_next;
  logic [KEY_POS_W-1:0]    key_position, key_position_next;
  logic [1:0]              key_match_flags, key_match_flags_next;
  logic                    escape_pending, escape_pending_next;
  logic [DEPTH_BITS-1:0]   skip_depth, skip_depth_next;
  logic                    current_list, current_list_next;
  logic [INDEX_BITS-1:0]   byte_position, byte_position_next;
  err_kind_t               sticky_error, sticky_error_next;
  logic                    closed_flag, closed_flag_next;

  // Output register.
  logic                    out_valid;
  logic                    r_char_valid;
  logic [7:0]              r_char_value;
  logic                    r_list_id;
  logic                    r_list_start;
  logic                    r_element_end;
  status_t                 r_status;
  err_kind_t               r_error_kind;
  logic [ERR_INDEX_W-1:0]  r_error_index;

  // Combinational result of the current byte.
  logic                    c_char_valid;
  logic                    c_list_id;
  logic                    c_list_start;
  logic                    c_element_end;
  status_t                 c_status;

  logic                    accept;
  logic                    ws;
  logic [7:0]              b;
  err_kind_t               fail_kind;
  logic [INDEX_BITS-1:0]   eof_index;

  assign b      = byte_in.byte_value;
  assign ws     = is_space(b);
  assign byte_in.ready = !out_valid || result.ready;
  assign accept = byte_in.valid && byte_in.ready;

  // Next state: one parse step, then the end-of-file judgment on the last byte.
  always_comb begin
    phase_next           = phase;
    key_position_next    = key_position;
    key_match_flags_next = key_match_flags;
    escape_pending_next  = escape_pending;
    skip_depth_next      = skip_depth;
    current_list_next    = current_list;
    byte_position_next   = byte_position;
    sticky_error_next    = sticky_error;
    closed_flag_next     = closed_flag;
    fail_kind            = ERR_NONE;
    eof_index            = '0;

    unique case (phase)
      PH_OPEN: begin
        if (!ws) begin
          if (b == CH_LBRACE) phase_next = PH_KEYWAIT;
          else fail_kind = ERR_BRACE;
        end
      end
      PH_KEYWAIT, PH_NEXT: begin
        if (!ws) begin
          if (phase == PH_NEXT && b == CH_COMMA) begin
            phase_next = PH_KEYWAIT;
          end else if (b == CH_RBRACE) begin
            closed_flag_next = 1'b1;
            phase_next       = PH_DONE;
          end else if (b == CH_QUOTE) begin
            phase_next           = PH_KEY;
            key_position_next    = '0;
            key_match_flags_next = 2'b11;
            escape_pending_next  = 1'b0;
          end else begin
            fail_kind = ERR_STRING;
          end
        end
      end
      PH_KEY: begin
        if (!escape_pending && b == CH_BACKSLASH) begin
          escape_pending_next = 1'b1;
        end else if (!escape_pending && b == CH_QUOTE) begin
          // Close the key: a match needs the full length too.
          if (key_position != KEY_WORDS_LEN)   key_match_flags_next[0] = 1'b0;
          if (key_position != KEY_SERVERS_LEN) key_match_flags_next[1] = 1'b0;
          phase_next = PH_COLON;
        end else begin
          escape_pending_next = 1'b0;
          if (!words_match(key_position, b))   key_match_flags_next[0] = 1'b0;
          if (!servers_match(key_position, b)) key_match_flags_next[1] = 1'b0;
          if (key_position != KEY_POS_MAX) key_position_next = key_position + 1'b1;
        end
      end
      PH_COLON: begin
        if (!ws) begin
          if (b == CH_COLON) phase_next = PH_VALUE;
          else fail_kind = ERR_COLON;
        end
      end
      PH_VALUE: begin
        if (!ws) begin
          if (key_match_flags != 2'b00) begin
            if (b == CH_LBRACKET) begin
              current_list_next = !key_match_flags[0];
              phase_next        = PH_ARR;
            end else begin
              fail_kind = ERR_BRACKET;
            end
          end else if (b == CH_QUOTE) begin
            phase_next          = PH_SKIPSTR;
            escape_pending_next = 1'b0;
          end else if (b == CH_LBRACKET) begin
            phase_next      = PH_SKIPARR;
            skip_depth_next = DEPTH_BITS'(1);
          end else begin
            fail_kind = ERR_VALUE_TYPE;
          end
        end
      end
      PH_SKIPSTR: begin
        if (!escape_pending && b == CH_BACKSLASH) escape_pending_next = 1'b1;
        else if (!escape_pending && b == CH_QUOTE) phase_next = PH_NEXT;
        else escape_pending_next = 1'b0;
      end
      PH_SKIPARR: begin
        // Count brackets blindly, strings included.
        if (b == CH_LBRACKET) begin
          if (skip_depth != DEPTH_MAX) skip_depth_next = skip_depth + 1'b1;
        end else if (b == CH_RBRACKET) begin
          if (skip_depth != '0) skip_depth_next = skip_depth - 1'b1;
          if (skip_depth <= DEPTH_BITS'(1)) phase_next = PH_NEXT;
        end
      end
      PH_ARR, PH_ARRNEXT: begin
        if (!ws) begin
          if (phase == PH_ARRNEXT && b == CH_COMMA) begin
            phase_next = PH_ARR;
          end else if (b == CH_RBRACKET) begin
            phase_next = PH_NEXT;
          end else if (b == CH_QUOTE) begin
            phase_next          = PH_ELEM;
            escape_pending_next = 1'b0;
          end else begin
            fail_kind = ERR_STRING;
          end
        end
      end
      PH_ELEM: begin
        if (!escape_pending && b == CH_BACKSLASH) escape_pending_next = 1'b1;
        else if (!escape_pending && b == CH_QUOTE) phase_next = PH_ARRNEXT;
        else escape_pending_next = 1'b0;
      end
      default: phase_next = PH_DONE;
    endcase

    if (fail_kind != ERR_NONE) begin
      sticky_error_next = fail_kind;
      phase_next        = PH_DONE;
    end

    // Advance the byte index while parsing; freeze it once done.
    if (phase_next != PH_DONE && byte_position != INDEX_MAX)
      byte_position_next = byte_position + 1'b1;

    // Judge an unfinished parse at end of file.
    if (byte_in.last && phase_next != PH_DONE) begin
      eof_index = byte_position_next;
      if (escape_pending_next && eof_index != INDEX_MAX) eof_index = eof_index + 1'b1;
      fail_kind = ERR_NONE;
      case (phase_next)
        PH_OPEN:                     fail_kind = ERR_BRACE;
        PH_KEY, PH_SKIPSTR, PH_ELEM: fail_kind = ERR_UNTERMINATED;
        PH_COLON:                    fail_kind = ERR_COLON;
        PH_VALUE: fail_kind = (key_match_flags_next != 2'b00) ? ERR_BRACKET : ERR_VALUE_TYPE;
        PH_ARR, PH_ARRNEXT:          fail_kind = ERR_STRING;
        default:                     fail_kind = ERR_NONE;
      endcase
      if (fail_kind != ERR_NONE) begin
        sticky_error_next  = fail_kind;
        byte_position_next = eof_index;
      end else begin
        closed_flag_next = 1'b1;
      end
      phase_next = PH_DONE;
    end
  end

  // Outputs of the current byte: list marks and characters.
  always_comb begin
    c_char_valid  = 1'b0;
    c_list_id     = 1'b0;
    c_list_start  = 1'b0;
    c_element_end = 1'b0;
    unique case (phase)
      PH_VALUE: begin
        if (!ws && key_match_flags != 2'b00 && b == CH_LBRACKET) begin
          c_list_start = 1'b1;
          c_list_id    = !key_match_flags[0];
        end
      end
      PH_ELEM: begin
        if (!escape_pending && b == CH_BACKSLASH) begin
          c_list_id = 1'b0;
        end else if (!escape_pending && b == CH_QUOTE) begin
          c_element_end = 1'b1;
          c_list_id     = current_list;
        end else begin
          c_char_valid = 1'b1;
          c_list_id    = current_list;
        end
      end
      default: c_list_id = 1'b0;
    endcase
    if (sticky_error_next != ERR_NONE) c_status = ST_FAILED;
    else if (byte_in.last)             c_status = ST_COMPLETED;
    else                               c_status = ST_RUNNING;
  end

  // Parser state: take the step on each accepted byte, restart after the last.
  always_ff @(posedge clk) begin
    if (rst || (accept && byte_in.last)) begin
      phase           <= PH_OPEN;
      key_position    <= '0;
      key_match_flags <= 2'b11;
      escape_pending  <= 1'b0;
      skip_depth      <= '0;
      current_list    <= 1'b0;
      byte_position   <= '0;
      sticky_error    <= ERR_NONE;
      closed_flag     <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      key_position    <= key_position_next;
      key_match_flags <= key_match_flags_next;
      escape_pending  <= escape_pending_next;
      skip_depth      <= skip_depth_next;
      current_list    <= current_list_next;
      byte_position   <= byte_position_next;
      sticky_error    <= sticky_error_next;
      closed_flag     <= closed_flag_next;
    end
  end

  // Output register: load on accept, drop valid once drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_char_valid  <= c_char_valid;
      r_char_value  <= c_char_valid ? b : 8'h00;
      r_list_id     <= c_list_id;
      r_list_start  <= c_list_start;
      r_element_end <= c_element_end;
      r_status      <= c_status;
      r_error_kind  <= (sticky_error_next != ERR_NONE) ? sticky_error_next : ERR_NONE;
      r_error_index <= (sticky_error_next != ERR_NONE) ?
                       ERR_INDEX_W'(byte_position_next) : '0;
    end
  end

  assign result.valid       = out_valid;
  assign result.char_valid  = r_char_valid;
  assign result.char_value  = r_char_value;
  assign result.list_id     = r_list_id;
  assign result.list_start  = r_list_start;
  assign result.element_end = r_element_end;
  assign result.status      = r_status;
  assign result.error_kind  = r_error_kind;
  assign result.error_index = r_error_index;

  // A closed or failed parse always sits in the done phase.
  a_closed_done: assert property (@(posedge clk) disable iff (rst)
    (closed_flag || sticky_error != ERR_NONE) |-> phase == PH_DONE)
    else $error("closed or failed parse outside done phase");

  // Bracket depth is only held while skipping an array.
  a_depth_skip: assert property (@(posedge clk) disable iff (rst)
    skip_depth != '0 |-> phase == PH_SKIPARR)
    else $error("skip depth left nonzero outside skipped array");

  // The last byte restarts the parser.
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_in.last) |=> (phase == PH_OPEN && byte_position == '0))
    else $error("parser did not restart after last byte");

  // A character result carries no list mark.
  a_char_marks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && r_char_valid) |-> (!r_list_start && !r_element_end))
    else $error("character result also carries a list mark");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the JSON list extractor: directed files, then random files.
`timescale 1ns / 1ps
module tb_top;
  import jsle_pkg::*;

  // One parse result as the result channel carries it.
  typedef struct packed {
    logic        char_valid;
    logic [7:0]  char_value;
    logic        list_id;
    logic        list_start;
    logic        element_end;
    status_t     status;
    err_kind_t   error_kind;
    logic [23:0] error_index;
  } extract_result_t;

  // Row of the directed table. Where typed is set, the status fields are the
  // expected result as written; the char fields are then all zero.
  typedef struct packed {
    logic [7:0]  value;
    logic        fin;
    logic        typed;
    status_t     st;
    err_kind_t   kind;
    logic [23:0] idx;
  } directed_row_t;

  // Short files: a bad first byte, an empty object without its brace, a member
  // that does not start with a quote (and the byte after the error, which only
  // reports it), a key cut off right after a backslash, and one servers list
  // holding one element with a high character value.
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    '{8'hFF,        1'b1, 1'b1, ST_FAILED,    ERR_BRACE,        24'd0},
    '{CH_LBRACE,    1'b1, 1'b1, ST_COMPLETED, ERR_NONE,         24'd0},
    '{CH_LBRACE,    1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_COLON,     1'b0, 1'b1, ST_FAILED,    ERR_STRING,       24'd1},
    '{8'h00,        1'b1, 1'b1, ST_FAILED,    ERR_STRING,       24'd1},
    '{CH_LBRACE,    1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_QUOTE,     1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_BACKSLASH, 1'b1, 1'b1, ST_FAILED,    ERR_UNTERMINATED, 24'd4},
    '{CH_LBRACE,    1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_QUOTE,     1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{"s",          1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{"e",          1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{"r",          1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{"v",          1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{"e",          1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{"r",          1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{"s",          1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_QUOTE,     1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_COLON,     1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_LBRACKET,  1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_QUOTE,     1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{8'hFE,        1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_QUOTE,     1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_RBRACKET,  1'b0, 1'b0, ST_RUNNING,   ERR_NONE,         24'd0},
    '{CH_RBRACE,    1'b1, 1'b1, ST_COMPLETED, ERR_NONE,         24'd0}
  };

  localparam logic [7:0] BLANK_BYTES [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  logic clk;
  logic rst;

  jsle_byte_if   byte_ch ();
  jsle_result_if res_ch ();

  json_subset_list_extractor_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .result  (res_ch)
  );

  // Shadow copy of the parser state.
  phase_t                 ph;
  logic [KEY_POS_W-1:0]   key_idx;
  logic [1:0]             key_hits;   // bit 0: still "searchWords", bit 1: still "servers"
  logic                   esc;
  logic [DEPTH_BITS-1:0]  skip_lvl;
  logic                   cur_list;
  logic [INDEX_BITS-1:0]  pos_cnt;
  err_kind_t              err;

  extract_result_t parse_results_q [$];  // results owed by the block, oldest first
  logic [7:0]      json_bytes [$];       // file being built for the byte channel

  int fail_cnt  = 0;
  int idle_pct  = 0;   // chance in a hundred that the sender skips a cycle
  int stall_pct = 0;   // chance in a hundred that the receiver drops ready
  int hold_left = 0;   // cycles the receiver still holds off unconditionally

  // ------------------------------------------------------------------------
  // Parser prediction
  // ------------------------------------------------------------------------

  function automatic void clear_parser();
    ph       = PH_OPEN;
    key_idx  = '0;
    key_hits = 2'b11;
    esc      = 1'b0;
    skip_lvl = '0;
    cur_list = 1'b0;
    pos_cnt  = '0;
    err      = ERR_NONE;
  endfunction

  // Latch the first error; the byte index freezes at the failing byte.
  function automatic void stop_parse(input err_kind_t kind, input logic [INDEX_BITS-1:0] at);
    err     = kind;
    pos_cnt = at;
    ph      = PH_DONE;
  endfunction

  function automatic void open_member(input logic [7:0] b, input logic [INDEX_BITS-1:0] at);
    if (b == CH_RBRACE) begin
      ph = PH_DONE;
    end else if (b == CH_QUOTE) begin
      ph       = PH_KEY;
      key_idx  = '0;
      key_hits = 2'b11;
      esc      = 1'b0;
    end else begin
      stop_parse(ERR_STRING, at);
    end
  endfunction

  function automatic void open_element(input logic [7:0] b, input logic [INDEX_BITS-1:0] at);
    if (b == CH_RBRACKET) begin
      ph = PH_NEXT;
    end else if (b == CH_QUOTE) begin
      ph  = PH_ELEM;
      esc = 1'b0;
    end else begin
      stop_parse(ERR_STRING, at);
    end
  endfunction

  // Advance the shadow parser by one byte and return the result it owes.
  function automatic extract_result_t parse_json_byte(input logic [7:0] b, input logic fin);
    extract_result_t        r;
    logic [INDEX_BITS-1:0]  at;
    logic [INDEX_BITS-1:0]  end_at;
    logic                   blank;
    r     = '0;
    at    = pos_cnt;
    blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    case (ph)
      PH_OPEN: begin
        if (!blank) begin
          if (b == CH_LBRACE) ph = PH_KEYWAIT;
          else stop_parse(ERR_BRACE, at);
        end
      end
      PH_KEYWAIT: begin
        if (!blank) open_member(b, at);
      end
      PH_NEXT: begin
        if (!blank) begin
          if (b == CH_COMMA) ph = PH_KEYWAIT;
          else open_member(b, at);
        end
      end
      PH_KEY: begin
        if (!esc && b == CH_BACKSLASH) begin
          esc = 1'b1;
        end else if (!esc && b == CH_QUOTE) begin
          // a key only matches when it ends exactly at the name's length
          if (key_idx != KEY_WORDS_LEN) key_hits[0] = 1'b0;
          if (key_idx != KEY_SERVERS_LEN) key_hits[1] = 1'b0;
          ph = PH_COLON;
        end else begin
          esc = 1'b0;
          if (key_idx >= KEY_WORDS_LEN || KEY_WORDS[key_idx] != b) key_hits[0] = 1'b0;
          if (key_idx >= KEY_SERVERS_LEN || KEY_SERVERS[key_idx[2:0]] != b) key_hits[1] = 1'b0;
          if (key_idx != KEY_POS_MAX) key_idx = key_idx + 1'b1;
        end
      end
      PH_COLON: begin
        if (!blank) begin
          if (b == CH_COLON) ph = PH_VALUE;
          else stop_parse(ERR_COLON, at);
        end
      end
      PH_VALUE: begin
        if (!blank) begin
          if (key_hits != 2'b00) begin
            if (b == CH_LBRACKET) begin
              cur_list     = !key_hits[0];
              ph           = PH_ARR;
              r.list_id    = cur_list;
              r.list_start = 1'b1;
            end else begin
              stop_parse(ERR_BRACKET, at);
            end
          end else if (b == CH_QUOTE) begin
            ph  = PH_SKIPSTR;
            esc = 1'b0;
          end else if (b == CH_LBRACKET) begin
            ph       = PH_SKIPARR;
            skip_lvl = DEPTH_BITS'(1);
          end else begin
            stop_parse(ERR_VALUE_TYPE, at);
          end
        end
      end
      PH_SKIPSTR: begin
        if (!esc && b == CH_BACKSLASH) esc = 1'b1;
        else if (!esc && b == CH_QUOTE) ph = PH_NEXT;
        else esc = 1'b0;
      end
      PH_SKIPARR: begin
        // brackets count at any depth, quoted or not; the count saturates
        if (b == CH_LBRACKET) begin
          if (skip_lvl != DEPTH_MAX) skip_lvl = skip_lvl + 1'b1;
        end else if (b == CH_RBRACKET) begin
          if (skip_lvl != '0) skip_lvl = skip_lvl - 1'b1;
          if (skip_lvl == '0) ph = PH_NEXT;
        end
      end
      PH_ARR: begin
        if (!blank) open_element(b, at);
      end
      PH_ARRNEXT: begin
        if (!blank) begin
          if (b == CH_COMMA) ph = PH_ARR;
          else open_element(b, at);
        end
      end
      PH_ELEM: begin
        if (!esc && b == CH_BACKSLASH) begin
          esc = 1'b1;
        end else if (!esc && b == CH_QUOTE) begin
          ph            = PH_ARRNEXT;
          r.list_id     = cur_list;
          r.element_end = 1'b1;
        end else begin
          esc          = 1'b0;
          r.char_valid = 1'b1;
          r.char_value = b;
          r.list_id    = cur_list;
        end
      end
      default: ph = PH_DONE;
    endcase

    if (ph != PH_DONE && pos_cnt != INDEX_MAX) pos_cnt = pos_cnt + 1'b1;

    // Judge an unfinished file at its end.
    if (fin && ph != PH_DONE) begin
      end_at = pos_cnt;
      if (esc && end_at != INDEX_MAX) end_at = end_at + 1'b1;
      case (ph)
        PH_OPEN:                     stop_parse(ERR_BRACE, end_at);
        PH_KEY, PH_SKIPSTR, PH_ELEM: stop_parse(ERR_UNTERMINATED, end_at);
        PH_COLON:                    stop_parse(ERR_COLON, end_at);
        PH_VALUE:    stop_parse((key_hits != 2'b00) ? ERR_BRACKET : ERR_VALUE_TYPE, end_at);
        PH_ARR, PH_ARRNEXT:          stop_parse(ERR_STRING, end_at);
        default:                     ph = PH_DONE;
      endcase
    end

    if (err != ERR_NONE) begin
      r.status      = ST_FAILED;
      r.error_kind  = err;
      r.error_index = pos_cnt[23:0];
    end else begin
      r.status = fin ? ST_COMPLETED : ST_RUNNING;
    end

    if (fin) clear_parser();
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // File generation
  // ------------------------------------------------------------------------

  // Append one byte to the end of the file being built.
  function automatic void append_byte(input logic [7:0] c);
    json_bytes.insert(json_bytes.size(), c);
  endfunction

  function automatic void add_blank();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) append_byte(BLANK_BYTES[$urandom_range(0, 5)]);
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  // String contents without the quotes; any byte may follow a backslash.
  function automatic void add_quoted_body(input int max_len);
    int         n;
    logic [7:0] c;
    n = $urandom_range(0, max_len);
    repeat (n) begin
      if ($urandom_range(0, 6) == 0) begin
        append_byte(CH_BACKSLASH);
        append_byte(8'($urandom_range(0, 255)));
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
        append_byte(c);
      end
    end
  endfunction

  // Build one file: mostly a well-formed object with random content, then
  // maybe damage it (overwrite, cut short, insert). A few files are pure noise.
  function automatic void build_json_file();
    int   nm, ne, d, n, v, r, cut;
    logic picked;
    json_bytes.delete();

    if ($urandom_range(0, 15) == 0) begin
      if ($urandom_range(0, 1) != 0) append_byte(CH_LBRACE);
      n = $urandom_range(1, 6);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
      return;
    end

    add_blank();
    append_byte(CH_LBRACE);
    nm = $urandom_range(0, 3);
    for (int m = 0; m < nm; m++) begin
      add_blank();
      if (m > 0 && $urandom_range(0, 1) != 0) append_byte(CH_COMMA);
      add_blank();
      append_byte(CH_QUOTE);
      picked = 1'b1;
      case ($urandom_range(0, 6))
        0, 1: add_text("searchWords");
        2, 3: add_text("servers");
        4:    add_text("ser\\vers");   // escaped letter still matches
        5: begin
          picked = 1'b0;
          case ($urandom_range(0, 3))
            0:       add_text("search");
            1:       add_text("serversX");
            2:       add_text("searchWordss");
            default: add_text("Servers");
          endcase
        end
        default: begin
          picked = 1'b0;
          add_quoted_body(5);
        end
      endcase
      append_byte(CH_QUOTE);
      add_blank();
      append_byte(CH_COLON);
      add_blank();

      v = $urandom_range(0, 19);
      if (picked && v != 0) begin
        append_byte(CH_LBRACKET);
        ne = $urandom_range(0, 3);
        for (int e = 0; e < ne; e++) begin
          add_blank();
          if (e > 0 && $urandom_range(0, 1) != 0) append_byte(CH_COMMA);
          add_blank();
          append_byte(CH_QUOTE);
          add_quoted_body(5);
          append_byte(CH_QUOTE);
        end
        add_blank();
        append_byte(CH_RBRACKET);
      end else if (v == 1) begin
        append_byte("7");
      end else if (v < 10) begin
        append_byte(CH_QUOTE);
        add_quoted_body(5);
        append_byte(CH_QUOTE);
      end else begin
        d = $urandom_range(1, 3);
        repeat (d) append_byte(CH_LBRACKET);
        n = $urandom_range(0, 3);
        repeat (n) begin
          add_blank();
          case ($urandom_range(0, 2))
            0: begin
              append_byte(CH_QUOTE);
              add_quoted_body(4);
              append_byte(CH_QUOTE);
            end
            1:       add_text("\"[x]\"");
            default: add_text("[]");
          endcase
          if ($urandom_range(0, 1) != 0) append_byte(CH_COMMA);
        end
        repeat (d) append_byte(CH_RBRACKET);
      end
    end
    add_blank();
    if ($urandom_range(0, 9) != 0) append_byte(CH_RBRACE);
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
    end

    r = $urandom_range(0, 99);
    if (r < 10) begin
      json_bytes[$urandom_range(0, json_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 40) begin
      cut = $urandom_range(1, json_bytes.size());
      while (json_bytes.size() > cut) void'(json_bytes.pop_back());
    end else if (r < 45) begin
      json_bytes.insert($urandom_range(0, json_bytes.size()), 8'($urandom_range(0, 255)));
    end
  endfunction

  // ------------------------------------------------------------------------
  // Byte channel driver
  // ------------------------------------------------------------------------

  // Offer one byte, wait for the request to be taken, and queue what it owes.
  // Valid is only lowered when a gap is inserted, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input logic typed = 1'b0, input extract_result_t typed_res = '0);
    extract_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid      = 1'b1;
    byte_ch.byte_value = b;
    byte_ch.last       = fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predicted = parse_json_byte(b, fin);
    parse_results_q.insert(parse_results_q.size(), typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < json_bytes.size(); i++) send_byte(json_bytes[i], i == json_bytes.size() - 1);
  endtask

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // ------------------------------------------------------------------------
  // Clock, receiver, checker, time limit
  // ------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive ready at the falling edge: hold off while a forced stall runs,
  // otherwise stall at random at the current rate.
  initial begin : result_drain
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left    = hold_left - 1;
      end else begin
        res_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare every taken result with the oldest owed one.
  always @(posedge clk) begin : result_check
    extract_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (parse_results_q.size() == 0) begin
        $error("result request with nothing outstanding");
        fail_cnt++;
      end else begin
        want = parse_results_q.pop_front();
        check_field("char_valid",  want.char_valid,  res_ch.char_valid);
        check_field("char_value",  want.char_value,  res_ch.char_value);
        check_field("list_id",     want.list_id,     res_ch.list_id);
        check_field("list_start",  want.list_start,  res_ch.list_start);
        check_field("element_end", want.element_end, res_ch.element_end);
        check_field("status",      want.status,      res_ch.status);
        check_field("error_kind",  want.error_kind,  res_ch.error_kind);
        check_field("error_index", want.error_index, res_ch.error_index);
      end
    end
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin : run_limit
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  initial begin : stimulus
    extract_result_t typed_res;
    int              sent;
    int              waited;

    byte_ch.valid      = 1'b0;
    byte_ch.byte_value = 8'h00;
    byte_ch.last       = 1'b0;
    rst                = 1'b1;
    clear_parser();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed table: typed rows carry their own expectation.
    foreach (DIRECTED_ROWS[i]) begin
      typed_res             = '0;
      typed_res.status      = DIRECTED_ROWS[i].st;
      typed_res.error_kind  = DIRECTED_ROWS[i].kind;
      typed_res.error_index = DIRECTED_ROWS[i].idx;
      send_byte(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed, typed_res);
    end

    // Random files in four load phases: free flow, sparse sender,
    // slow receiver, both sides gapped.
    for (int lp = 0; lp < 4; lp++) begin
      case (lp)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      // Hold off the receiver for a long stretch while bytes keep coming,
      // so the output register fills and the input stalls.
      if (lp == 0) hold_left = 60;
      sent = 0;
      while (sent < 120) begin
        build_json_file();
        sent = sent + json_bytes.size();
        send_file();
      end
    end

    // Drain: stop stalling and wait for every owed result.
    byte_ch.valid = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    waited        = 0;
    while (parse_results_q.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (parse_results_q.size() != 0) begin
      $error("%0d results never arrived", parse_results_q.size());
      fail_cnt++;
    end

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
